[rtl/dsr_pkg.sv]
// Shared types, widths, register indexes and helpers of the disc span rasterizer.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package dsr_pkg;

    // Field widths of the channels.
    localparam int XF_W      = 17;
    localparam int COLOR_W   = 24;
    localparam int CFG_W     = 13;
    localparam int RAD_W     = 5;
    localparam int COORD_W   = 12;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Internal widths.
    localparam int CNT_W  = RAD_W + 1;   // window counter, holds 2r
    localparam int POS_W  = 16;          // signed pixel position
    localparam int Q_W    = 32;          // signed Q16.16 centre
    localparam int DIFF_W = 24;          // signed Q8.16 offset to the centre
    localparam int PROD_W = 2 * DIFF_W;  // product of the shared multiplier
    localparam int FRAC_W = 16;

    // Parameter defaults.
    localparam int MAX_DIM_DEF    = 4096;
    localparam int MAX_RADIUS_DEF = 31;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd256;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd256;
    localparam logic [RAD_W-1:0] RADIUS_RST = 5'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULX,
        ST_MULY,
        ST_ORGX,
        ST_ORGY,
        ST_ROWSQ,
        ST_ROWWT,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } dsr_state_t;

    typedef enum logic [1:0] {
        MUL_XW,
        MUL_YH,
        MUL_DY,
        MUL_DX
    } dsr_mul_sel_t;

    typedef struct packed {
        logic         load;
        dsr_mul_sel_t mul_sel;
        logic         take_cx;
        logic         take_cy;
        logic         set_ox;
        logic         set_oy;
        logic         row_start;
        logic         take_dy2;
        logic         scan;
        logic         emit;
        logic         next_row;
    } dsr_cmd_t;

    typedef struct packed {
        logic col_last;
        logic row_last;
        logic out_free;
    } dsr_stat_t;

    // Q16.16 to integer, rounding toward zero for both signs.
    function automatic logic signed [POS_W-1:0] trunc_q16(input logic signed [Q_W-1:0] v);
        logic [Q_W-1:0] mag;
        logic [Q_W-1:0] res;
        mag = v[Q_W-1] ? (~v + Q_W'(1)) : v;
        res = mag >> FRAC_W;
        if (v[Q_W-1])
        begin
            res = ~res + Q_W'(1);
        end
        return res[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/dsr_ifs.sv]
// Valid/ready channel interfaces of the disc span rasterizer: points, spans, register writes.
// Depends on dsr_pkg for the field widths.
`default_nettype none

interface dsr_point_if import dsr_pkg::*;;
    logic               valid;
    logic               ready;
    logic [XF_W-1:0]    x_frac;
    logic [XF_W-1:0]    y_frac;
    logic [COLOR_W-1:0] color;

    modport source (output valid, output x_frac, output y_frac, output color, input ready);
    modport sink (input valid, input x_frac, input y_frac, input color, output ready);
endinterface

interface dsr_span_if import dsr_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col_first;
    logic [COORD_W-1:0] col_final;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               empty_res;
    logic               last;

    modport source (output valid, output row, output col_first, output col_final,
                    output red, output green, output blue, output empty_res, output last,
                    input ready);
    modport sink (input valid, input row, input col_first, input col_final,
                  input red, input green, input blue, input empty_res, input last,
                  output ready);
endinterface

interface dsr_cfg_if import dsr_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/dsr_ctrl.sv]
// Sequencer of the disc span rasterizer: steps the datapath through setup, row scans and emits.
// Depends on dsr_pkg for the state, command and status types.
`default_nettype none

module dsr_ctrl import dsr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire dsr_stat_t stat,
    output dsr_cmd_t       cmd
);

    dsr_state_t state_reg;
    dsr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX:  state_next = ST_MULY;
            ST_MULY:  state_next = ST_ORGX;
            ST_ORGX:  state_next = ST_ORGY;
            ST_ORGY:  state_next = ST_ROWSQ;
            ST_ROWSQ: state_next = ST_ROWWT;
            ST_ROWWT: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (stat.col_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.row_last ? ST_IDLE : ST_ROWSQ;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.mul_sel = MUL_DX;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MULX:
            begin
                cmd.mul_sel = MUL_XW;
            end
            ST_MULY:
            begin
                cmd.mul_sel = MUL_YH;
                cmd.take_cx = 1'b1;
            end
            ST_ORGX:
            begin
                cmd.take_cy = 1'b1;
                cmd.set_ox  = 1'b1;
            end
            ST_ORGY:
            begin
                cmd.set_oy = 1'b1;
            end
            ST_ROWSQ:
            begin
                cmd.mul_sel   = MUL_DY;
                cmd.row_start = 1'b1;
            end
            ST_ROWWT:
            begin
                cmd.take_dy2 = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.mul_sel = MUL_DX;
                cmd.scan    = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_EMIT:
            begin
                cmd.emit     = stat.out_free;
                cmd.next_row = stat.out_free && !stat.row_last;
            end
            default:
            begin
            end
        endcase
    end

    // A request is taken only from idle, and it always starts the setup sequence.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_MULX)
        else $error("accepted request did not start setup");

    // The span that closes a point returns the sequencer to idle.
    a_last_span_idles: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && stat.row_last |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after the final span");

    // A row scan always ends through the drain cycle into the emit state.
    a_drain_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && stat.col_last |=> ##1 state_reg == ST_EMIT)
        else $error("row scan did not reach the emit state");

endmodule

`default_nettype wire

[rtl/dsr_datapath.sv]
// Datapath of the disc span rasterizer: registers, shared multiplier, coverage test and span clip.
// Depends on dsr_pkg; driven by dsr_ctrl through command and status structs.
`default_nettype none

module dsr_datapath import dsr_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [XF_W-1:0]      x_frac,
    input  wire logic [XF_W-1:0]      y_frac,
    input  wire logic [COLOR_W-1:0]   color,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [COORD_W-1:0]        row,
    output logic [COORD_W-1:0]        col_first,
    output logic [COORD_W-1:0]        col_final,
    output logic [CHAN_W-1:0]         red,
    output logic [CHAN_W-1:0]         green,
    output logic [CHAN_W-1:0]         blue,
    output logic                      empty_res,
    output logic                      last,
    input  wire dsr_cmd_t             cmd,
    output dsr_stat_t                 stat
);

    localparam int D2_W  = PROD_W - 1;
    localparam int D2I_W = D2_W - 2 * FRAC_W;

    // Configuration registers.
    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [RAD_W-1:0] radius_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RST;
            height_cfg_reg <= HEIGHT_RST;
            radius_cfg_reg <= RADIUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_cfg_reg  <= cfg_data;
                REG_HEIGHT: height_cfg_reg <= cfg_data;
                REG_RADIUS: radius_cfg_reg <= cfg_data[RAD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Limits applied to the registers.
    logic [CFG_W-1:0]   w_eff;
    logic [CFG_W-1:0]   h_eff;
    logic [RAD_W-1:0]   r_eff;
    logic [2*RAD_W-1:0] r_sq;

    assign w_eff = (32'(width_cfg_reg) > 32'(MAX_DIM)) ? CFG_W'(MAX_DIM) : width_cfg_reg;
    assign h_eff = (32'(height_cfg_reg) > 32'(MAX_DIM)) ? CFG_W'(MAX_DIM) : height_cfg_reg;
    assign r_eff = (32'(radius_cfg_reg) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                           : radius_cfg_reg;
    assign r_sq  = r_eff * r_eff;

    // Per-point operands.
    logic [XF_W-1:0]    xf_reg;
    logic [XF_W-1:0]    yf_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [CFG_W-1:0]   w_reg;
    logic [CFG_W-1:0]   h_reg;
    logic [RAD_W-1:0]   r_reg;
    logic [2*RAD_W-1:0] r2_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xf_reg    <= x_frac;
            yf_reg    <= y_frac;
            color_reg <= color;
            w_reg     <= w_eff;
            h_reg     <= h_eff;
            r_reg     <= r_eff;
            r2_reg    <= r_sq;
        end
    end

    // Shared multiplier with a registered product.
    logic signed [DIFF_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_XW:
            begin
                mul_a = $signed(DIFF_W'(xf_reg));
                mul_b = $signed(DIFF_W'(w_reg));
            end
            MUL_YH:
            begin
                mul_a = $signed(DIFF_W'(yf_reg));
                mul_b = $signed(DIFF_W'(h_reg));
            end
            MUL_DY:
            begin
                mul_a = dy;
                mul_b = dy;
            end
            MUL_DX:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            default:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Centre, window origin and offsets.
    logic signed [Q_W-1:0]    cx_reg;
    logic signed [Q_W-1:0]    cy_reg;
    logic signed [Q_W-1:0]    r_off;
    logic signed [POS_W-1:0]  ox_reg;
    logic signed [POS_W-1:0]  j_reg;
    logic signed [POS_W-1:0]  i_reg;
    logic signed [POS_W-1:0]  pi_reg;
    logic signed [Q_W-1:0]    dy_full;
    logic signed [Q_W-1:0]    dx_full;
    logic signed [PROD_W-1:0] dy2_reg;
    logic [CNT_W-1:0]         ki_reg;
    logic [CNT_W-1:0]         kj_reg;
    logic [CNT_W-1:0]         span_max;
    logic                     pv_reg;

    assign r_off    = $signed(Q_W'({r_reg, FRAC_W'(0)}));
    assign dy_full  = $signed({j_reg, FRAC_W'(0)}) - cy_reg;
    assign dx_full  = $signed({ox_reg, FRAC_W'(0)}) - cx_reg;
    assign dy       = dy_full[DIFF_W-1:0];
    assign span_max = {r_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.take_cx)
        begin
            cx_reg <= prod_reg[Q_W-1:0];
        end
        if (cmd.take_cy)
        begin
            cy_reg <= prod_reg[Q_W-1:0];
        end
        if (cmd.set_ox)
        begin
            ox_reg <= trunc_q16(cx_reg - r_off);
        end
        if (cmd.set_oy)
        begin
            j_reg <= trunc_q16(cy_reg - r_off);
        end
        else if (cmd.next_row)
        begin
            j_reg <= j_reg + POS_W'(1);
        end
        if (cmd.row_start)
        begin
            i_reg  <= ox_reg;
            dx_reg <= dx_full[DIFF_W-1:0];
        end
        else if (cmd.scan)
        begin
            i_reg  <= i_reg + POS_W'(1);
            dx_reg <= dx_reg + $signed(DIFF_W'(1) << FRAC_W);
        end
        if (cmd.take_dy2)
        begin
            dy2_reg <= prod_reg;
        end
        pi_reg <= i_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ki_reg <= '0;
            kj_reg <= '0;
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.scan;
            if (cmd.row_start)
            begin
                ki_reg <= '0;
            end
            else if (cmd.scan)
            begin
                ki_reg <= ki_reg + CNT_W'(1);
            end
            if (cmd.set_oy)
            begin
                kj_reg <= '0;
            end
            else if (cmd.next_row)
            begin
                kj_reg <= kj_reg + CNT_W'(1);
            end
        end
    end

    // Coverage test, one column behind the multiplier.
    logic [D2_W-1:0]         d2;
    logic                    hit;
    logic                    found_reg;
    logic signed [POS_W-1:0] first_reg;
    logic signed [POS_W-1:0] lastcol_reg;

    assign d2  = prod_reg[D2_W-1:0] + dy2_reg[D2_W-1:0];
    assign hit = d2[D2_W-1:2*FRAC_W] <= D2I_W'(r2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.row_start)
        begin
            found_reg <= 1'b0;
        end
        else if (pv_reg && hit)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pv_reg && hit)
        begin
            if (!found_reg)
            begin
                first_reg <= pi_reg;
            end
            lastcol_reg <= pi_reg;
        end
    end

    // Clip the span to the image.
    logic signed [POS_W-1:0] w_s;
    logic signed [POS_W-1:0] h_s;
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic                    row_in;
    logic                    span_empty;

    assign w_s        = $signed(POS_W'(w_reg));
    assign h_s        = $signed(POS_W'(h_reg));
    assign row_in     = !j_reg[POS_W-1] && (j_reg < h_s);
    assign lo         = first_reg[POS_W-1] ? '0 : first_reg;
    assign hi         = (lastcol_reg > w_s - POS_W'(1)) ? (w_s - POS_W'(1)) : lastcol_reg;
    assign span_empty = !(found_reg && row_in && (w_reg != '0) && (lo <= hi));

    // Output register.
    logic               out_valid_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] first_out_reg;
    logic [COORD_W-1:0] final_out_reg;
    logic [CHAN_W-1:0]  red_reg;
    logic [CHAN_W-1:0]  green_reg;
    logic [CHAN_W-1:0]  blue_reg;
    logic               empty_reg;
    logic               last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            row_reg       <= span_empty ? '0 : j_reg[COORD_W-1:0];
            first_out_reg <= span_empty ? '0 : lo[COORD_W-1:0];
            final_out_reg <= span_empty ? '0 : hi[COORD_W-1:0];
            red_reg       <= color_reg[23:16];
            green_reg     <= color_reg[15:8];
            blue_reg      <= color_reg[7:0];
            empty_reg     <= span_empty;
            last_reg      <= (kj_reg == span_max);
        end
    end

    assign out_valid = out_valid_reg;
    assign row       = row_reg;
    assign col_first = first_out_reg;
    assign col_final = final_out_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign empty_res = empty_reg;
    assign last      = last_reg;

    assign stat.col_last = (ki_reg == span_max);
    assign stat.row_last = (kj_reg == span_max);
    assign stat.out_free = !out_valid_reg || out_ready;

    // The output register is only loaded when it is free or being drained.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("span overwrote an untaken span");

    // The column scan never runs past the window edge.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> ki_reg <= span_max)
        else $error("column scan ran past the window");

    // A non-empty span is well ordered; an empty one carries zero coordinates.
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !empty_reg |-> first_out_reg <= final_out_reg)
        else $error("span ends before it begins");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && empty_reg |->
            row_reg == '0 && first_out_reg == '0 && final_out_reg == '0)
        else $error("empty span carries coordinates");

endmodule

`default_nettype wire

[rtl/disc_span_rasterizer.sv]
// Top level of the disc span rasterizer: channel wiring around the sequencer and the datapath.
// Depends on dsr_pkg, dsr_ifs, dsr_ctrl and dsr_datapath.
//
// Usage. Each request on the points channel carries a point (x_frac, y_frac as unsigned
// Q1.16 fractions of the image size) and a 24-bit color. For a disc radius r the block
// answers with 2r+1 requests on the spans channel, one per row of the window around the
// point, top row first; the final one has last set. Each span gives the row and the first
// and final covered columns, clipped to the image, or empty_res set with zero coordinates.
// The cfg channel writes image_width (index 0), image_height (index 1) and disc_radius
// (index 2); it is always ready and must only be used while the block is idle.
//
// Timing. The block handles one point at a time. Setup runs on the shared multiplier,
// then every row takes a squaring of the row offset, a settle cycle, one multiplier
// pass per window column, a drain cycle and the emit.
//
// Reset clears the sequencer and the output valid, and loads width 256, height 256 and
// radius 4. When the receiver stalls, the finished span waits in the output register and
// the sequencer holds in its emit state; a new point is accepted while the last span of
// the previous one is still waiting.
`default_nettype none

module disc_span_rasterizer import dsr_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
)
(
    input wire logic   clk,
    input wire logic   rst_n,
    dsr_cfg_if.sink    cfg,
    dsr_point_if.sink  points,
    dsr_span_if.source spans
);

    dsr_cmd_t  cmd;
    dsr_stat_t stat;
    logic      in_ready;

    // Register writes are never back-pressured.
    assign cfg.ready    = 1'b1;
    assign points.ready = in_ready;

    dsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (points.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dsr_datapath #(
        .MAX_DIM    (MAX_DIM),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .x_frac    (points.x_frac),
        .y_frac    (points.y_frac),
        .color     (points.color),
        .out_valid (spans.valid),
        .out_ready (spans.ready),
        .row       (spans.row),
        .col_first (spans.col_first),
        .col_final (spans.col_final),
        .red       (spans.red),
        .green     (spans.green),
        .blue      (spans.blue),
        .empty_res (spans.empty_res),
        .last      (spans.last),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

[sim/dsr_span_checker.sv]
// Span checker for the disc span rasterizer: follows register writes, predicts the spans
// of every accepted point and compares them with the spans that the block hands out.
// Depends on dsr_pkg and the channel interfaces in dsr_ifs.
`timescale 1ns / 1ps

module dsr_span_checker import dsr_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    dsr_cfg_if       cfg,
    dsr_point_if     points,
    dsr_span_if      spans,
    output int       mismatches,
    output int       outstanding
);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col_first;
        logic [COORD_W-1:0] col_final;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               empty_res;
        logic               last;
    } span_t;

    logic [CFG_W-1:0] width_q;
    logic [CFG_W-1:0] height_q;
    logic [RAD_W-1:0] radius_q;
    span_t            spans_due[$];
    int               fail_count;

    // Q16.16 to integer, rounding toward zero on both sides of zero.
    function automatic longint q16_toward_zero(input longint v);
        if (v >= 0)
        begin
            return v >>> 16;
        end
        return -((-v) >>> 16);
    endfunction

    // Expected spans of one point: one per window row, top row first.
    task automatic expand_disc_rows(input logic [XF_W-1:0] xf, input logic [XF_W-1:0] yf,
                                    input logic [COLOR_W-1:0] rgb);
        longint w, h, rad, cx, cy, ox, oy, rsq, n, j, i, dy2, dx, first_col, last_col, lo, hi;
        bit     hit;
        bit     empty;
        span_t  s;
        w = longint'(width_q);
        h = longint'(height_q);
        rad = longint'(radius_q);
        if (w > MAX_DIM_DEF)
        begin
            w = MAX_DIM_DEF;
        end
        if (h > MAX_DIM_DEF)
        begin
            h = MAX_DIM_DEF;
        end
        if (rad > MAX_RADIUS_DEF)
        begin
            rad = MAX_RADIUS_DEF;
        end
        cx = longint'(xf) * w;
        cy = longint'(yf) * h;
        ox = q16_toward_zero(cx - rad * 65536);
        oy = q16_toward_zero(cy - rad * 65536);
        rsq = rad * rad;
        n = 2 * rad + 1;
        for (longint kj = 0; kj < n; kj++)
        begin
            j = oy + kj;
            dy2 = (j * 65536 - cy) * (j * 65536 - cy);
            hit = 1'b0;
            first_col = 0;
            last_col = 0;
            for (longint ki = 0; ki < n; ki++)
            begin
                i = ox + ki;
                dx = i * 65536 - cx;
                // Covered when the integer part of the squared distance is within r*r.
                if (((dx * dx + dy2) >>> 32) <= rsq)
                begin
                    if (!hit)
                    begin
                        first_col = i;
                        hit = 1'b1;
                    end
                    last_col = i;
                end
            end
            empty = 1'b1;
            lo = 0;
            hi = 0;
            if (hit && j >= 0 && j < h && w > 0)
            begin
                lo = (first_col < 0) ? 0 : first_col;
                hi = (last_col > w - 1) ? w - 1 : last_col;
                empty = (lo > hi);
            end
            s.row = empty ? '0 : j[COORD_W-1:0];
            s.col_first = empty ? '0 : lo[COORD_W-1:0];
            s.col_final = empty ? '0 : hi[COORD_W-1:0];
            s.red = rgb[23:16];
            s.green = rgb[15:8];
            s.blue = rgb[7:0];
            s.empty_res = empty;
            s.last = (kj == n - 1);
            spans_due.push_back(s);
        end
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: span %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        span_t want;
        if (!rst_n)
        begin
            width_q <= WIDTH_RST;
            height_q <= HEIGHT_RST;
            radius_q <= RADIUS_RST;
            spans_due.delete();
            fail_count = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_WIDTH:  width_q <= cfg.data;
                    REG_HEIGHT: height_q <= cfg.data;
                    REG_RADIUS: radius_q <= cfg.data[RAD_W-1:0];
                    default:    ;
                endcase
            end

            // Spans leaving now belong to points accepted earlier, so compare before
            // the point accepted at this edge adds its rows.
            if (spans.valid && spans.ready)
            begin
                if (spans_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: span row %0d cols %0d..%0d arrived with no point pending",
                             $time, spans.row, spans.col_first, spans.col_final);
                end
                else
                begin
                    want = spans_due.pop_front();
                    check_field("row", 32'(want.row), 32'(spans.row));
                    check_field("col_first", 32'(want.col_first), 32'(spans.col_first));
                    check_field("col_final", 32'(want.col_final), 32'(spans.col_final));
                    check_field("red", 32'(want.red), 32'(spans.red));
                    check_field("green", 32'(want.green), 32'(spans.green));
                    check_field("blue", 32'(want.blue), 32'(spans.blue));
                    check_field("empty_res", 32'(want.empty_res), 32'(spans.empty_res));
                    check_field("last", 32'(want.last), 32'(spans.last));
                end
            end

            if (points.valid && points.ready)
            begin
                expand_disc_rows(points.x_frac, points.y_frac, points.color);
            end

            mismatches <= fail_count;
            outstanding <= spans_due.size();
        end
    end

endmodule

[sim/tb_disc_span_rasterizer.sv]
// Testbench top of the disc span rasterizer: clock, reset, register writes, point requests
// and span back-pressure, with the verdict taken from dsr_span_checker.
// Depends on dsr_pkg, dsr_ifs, disc_span_rasterizer and dsr_span_checker.
`timescale 1ns / 1ps

module tb_disc_span_rasterizer import dsr_pkg::*;;

    // Rough count of random point requests after the directed part.
    localparam int     RANDOM_ITEMS     = 120;
    // Cycles the span receiver holds off once, long enough to back up the point channel.
    localparam int     LONG_HOLD_CYCLES = 400;
    // Idle cycles after the last span before a register write; every point yields spans,
    // so the sequencer is already idle by then and this is only margin.
    localparam int     SETTLE_CYCLES    = 8;
    // Cycles to watch for stray spans once nothing is expected: longer than the first-span
    // latency at the largest radius.
    localparam int     TAIL_CYCLES      = 100;
    // Timeout of the whole run, far above what a correct run needs at the largest radius.
    localparam longint TIMEOUT_NS       = 64'd50_000_000;

    typedef enum logic [1:0] {
        SINK_EAGER,
        SINK_RANDOM,
        SINK_PERIODIC
    } sink_mode_t;

    logic       clk = 1'b0;
    logic       rst_n;
    int         mismatches;
    int         outstanding;
    sink_mode_t sink_mode = SINK_RANDOM;
    bit         long_hold = 1'b0;
    int         gap_max = 3;
    int         burst_left = 0;

    dsr_cfg_if   cfg_ch();
    dsr_point_if point_ch();
    dsr_span_if  span_ch();

    disc_span_rasterizer i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .points (point_ch),
        .spans  (span_ch)
    );

    dsr_span_checker i_span_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .points      (point_ch),
        .spans       (span_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // The run ends here if the block stops answering.
    initial
    begin
        #(TIMEOUT_NS);
        $display("disc_span_rasterizer test failed");
        $finish;
    end

    // Writes one register; the caller holds the write valid high around a group of writes
    // so that valid never drops and rises within the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_ch.index <= idx;
        cfg_ch.data <= value[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Loads the image size and the radius. Only called while the block is idle.
    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned rad);
        cfg_ch.valid <= 1'b1;
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_RADIUS, rad);
        cfg_ch.valid <= 1'b0;
    endtask

    // Offers one point request and returns at the edge where it is taken. Requests go out
    // in bursts of random length; between bursts the sender drops valid for a random gap.
    task automatic send_point(input logic [XF_W-1:0] xf, input logic [XF_W-1:0] yf,
                              input logic [COLOR_W-1:0] rgb);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                point_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        point_ch.valid <= 1'b1;
        point_ch.x_frac <= xf;
        point_ch.y_frac <= yf;
        point_ch.color <= rgb;
        @(posedge clk);
        while (!point_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Stops offering points and waits until every predicted span has come back. The first
    // edge lets the checker count the point that was taken at the current edge.
    task automatic drain_spans();
        point_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Image sizes: mostly ordinary ones, with zero, one, the maximum and an oversized
    // value mixed in.
    function automatic int unsigned pick_dim();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)
        begin
            return 0;
        end
        if (sel < 8)
        begin
            return (1 << CFG_W) - 1;
        end
        if (sel < 12)
        begin
            return MAX_DIM_DEF;
        end
        if (sel < 16)
        begin
            return 1;
        end
        if (sel < 60)
        begin
            return $urandom_range(2, 64);
        end
        return $urandom_range(65, MAX_DIM_DEF);
    endfunction

    // Radius: small ones dominate since the time a point takes grows with the square of r.
    function automatic int unsigned pick_radius();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            return $urandom_range(0, 6);
        end
        if (sel < 90)
        begin
            return $urandom_range(7, 15);
        end
        if (sel < 96)
        begin
            return $urandom_range(16, 24);
        end
        return MAX_RADIUS_DEF;
    endfunction

    // Fractions: mostly inside the image, some hugging the borders so spans get clipped,
    // some anywhere in the 17-bit range, which takes the window outside the image.
    function automatic logic [XF_W-1:0] pick_frac();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
        begin
            return XF_W'($urandom_range(0, 65536));
        end
        if (sel < 75)
        begin
            return XF_W'($urandom_range(0, 1024));
        end
        if (sel < 85)
        begin
            return XF_W'($urandom_range(64512, 65536));
        end
        if (sel < 95)
        begin
            return XF_W'($urandom);
        end
        return (sel < 97) ? XF_W'(0) : ((sel < 99) ? XF_W'(65536) : XF_W'(131071));
    endfunction

    // Span receiver. Its ready follows the mode of the current phase; once the stimulus
    // asks for it, ready stays low for a long stretch counted here.
    initial
    begin : span_receiver
        int unsigned beat;
        beat = 0;
        span_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            beat++;
            if (long_hold)
            begin
                span_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                case (sink_mode)
                    SINK_EAGER:    span_ch.ready <= 1'b1;
                    SINK_RANDOM:   span_ch.ready <= ($urandom_range(0, 9) < 7);
                    SINK_PERIODIC: span_ch.ready <= ((beat % 7) >= 3);
                    default:       span_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Stimulus: reset, a directed part over the corner cases, then random phases, each
    // with its own geometry, receiver mode and sender gap length.
    initial
    begin : stimulus
        int          phase;
        int          random_items;
        int          phase_items;
        int unsigned w;
        int unsigned h;
        int unsigned rad;
        rst_n <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_WIDTH;
        cfg_ch.data <= '0;
        point_ch.valid <= 1'b0;
        point_ch.x_frac <= '0;
        point_ch.y_frac <= '0;
        point_ch.color <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: 256 x 256, radius 4. Corners, the centre, both color extremes,
        // and fractions far above 1.0, which leave the whole window off the image.
        send_point(XF_W'(0), XF_W'(0), 24'h000000);
        send_point(XF_W'(65536), XF_W'(65536), 24'hFFFFFF);
        send_point(XF_W'(32768), XF_W'(32768), 24'hA5C35A);
        send_point(XF_W'(131071), XF_W'(131071), 24'h5A3CA5);
        send_point(XF_W'(65535), XF_W'(0), 24'h123456);
        send_point(XF_W'(256), XF_W'(65280), 24'h808080);
        drain_spans();

        // Largest image and largest radius: the window runs past every border.
        set_geometry(MAX_DIM_DEF, MAX_DIM_DEF, MAX_RADIUS_DEF);
        send_point(XF_W'(0), XF_W'(0), 24'hFF00FF);
        send_point(XF_W'(65536), XF_W'(65536), 24'h00FF00);
        send_point(XF_W'(32769), XF_W'(1), 24'h0F0F0F);
        drain_spans();

        // Zero width makes every row empty; the height is oversized and acts as the maximum.
        set_geometry(0, (1 << CFG_W) - 1, 0);
        send_point(XF_W'(32768), XF_W'(32768), 24'hFFFFFF);
        send_point(XF_W'(0), XF_W'(65536), 24'h000000);
        drain_spans();

        // Single-pixel image with radius one.
        set_geometry(1, 1, 1);
        send_point(XF_W'(0), XF_W'(0), 24'hC0FFEE);
        send_point(XF_W'(65536), XF_W'(65536), 24'h3C3C3C);
        send_point(XF_W'(32768), XF_W'(32768), 24'hE1E1E1);
        drain_spans();

        // Oversized width with zero height.
        set_geometry((1 << CFG_W) - 1, 0, 2);
        send_point(XF_W'(32768), XF_W'(32768), 24'h7F7F7F);
        send_point(XF_W'(65535), XF_W'(0), 24'h010203);
        drain_spans();

        // Radius zero on the largest image, right at the last row and column.
        set_geometry(MAX_DIM_DEF, MAX_DIM_DEF, 0);
        send_point(XF_W'(65535), XF_W'(65535), 24'hFEDCBA);
        send_point(XF_W'(65536), XF_W'(0), 24'h00FFFF);
        send_point(XF_W'(1), XF_W'(1), 24'hFFFF00);
        drain_spans();

        phase = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            w = pick_dim();
            h = pick_dim();
            rad = pick_radius();
            phase_items = $urandom_range(6, 20);
            sink_mode = sink_mode_t'($urandom_range(0, 2));
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 12;
            endcase
            if (phase == 1)
            begin
                // Back-pressure phase: the sender keeps offering with no gaps while the
                // receiver holds off, so the block fills up and stalls the point channel.
                rad = $urandom_range(1, 5);
                gap_max = 0;
            end
            if (rad > 15)
            begin
                phase_items = $urandom_range(1, 3);
            end
            set_geometry(w, h, rad);
            if (phase == 1)
            begin
                long_hold = 1'b1;
            end
            for (int k = 0; k < phase_items; k++)
            begin
                send_point(pick_frac(), pick_frac(), COLOR_W'($urandom));
                if (phase == 2 && k == phase_items / 2)
                begin
                    // The sender pauses mid-phase until every span is back.
                    drain_spans();
                end
            end
            drain_spans();
            random_items += phase_items;
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("disc_span_rasterizer test passed");
        end
        else
        begin
            $display("disc_span_rasterizer test failed");
        end
        $finish;
    end

endmodule

[disc_span_rasterizer.f]
rtl/dsr_pkg.sv
rtl/dsr_ifs.sv
rtl/dsr_ctrl.sv
rtl/dsr_datapath.sv
rtl/disc_span_rasterizer.sv
sim/dsr_span_checker.sv
sim/tb_disc_span_rasterizer.sv
